// ===== rtl/dmfwj_pkg.sv =====
// dmfwj_pkg: shared widths, reset values, register indexes and handshake types
// for the dial mode filter. No dependencies.
package dmfwj_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int GAIN_W          = 16;
    localparam int OFS_W           = 16;
    localparam int POS_W           = 18;
    localparam int DIAL_W          = 33;
    localparam int WINDOW_SIZE_DEF = 16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [SAMPLE_W-1:0] LOWER_RST = 12'd1024;
    localparam logic [SAMPLE_W-1:0] UPPER_RST = 12'd3072;
    localparam logic [GAIN_W-1:0]   GAIN_RST  = 16'd256;

    localparam logic signed [OFS_W-1:0] OFS_MAX = 16'sd32767;
    localparam logic signed [OFS_W-1:0] OFS_MIN = -16'sd32767;

    typedef enum logic [1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_GAIN  = 2'd2
    } dmfwj_reg_t;

    // mode unit result toward the top-level sequencer
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] mode;
    } dmfwj_mode_res_t;

endpackage

// ===== rtl/dial_mode_filter_window_jog_top.sv =====
// Dial mode filter with sliding deadband: top level, config registers, offset
// and output sequencer. Depends on dmfwj_pkg, dmfwj_window_mem, dmfwj_mode_unit.
//
// Each input beat stores one 12-bit sample and returns one output beat with the
// held dial value. A sample that does not complete the window loads its output
// beat straight from the idle state. The sample that completes a window starts a
// mode search that runs one equality compare per cycle while scanning the window
// memory through its single read port. The offset update, one 18x17 multiply and
// the output load follow in that order, and the input is held off from that
// sample's accept until its output beat is loaded and the sequencer is idle again.
// The output beat of that sample carries window_done set.
module dial_mode_filter_window_jog_top
    import dmfwj_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // APB config
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,  // [11:0] sample
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,  // [32:0] dial_value, [44:33] mode_reading
    output logic              m_tuser   // [0] window_done
);

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_SCAN = 4'b0010,
        T_MUL  = 4'b0100,
        T_OUT  = 4'b1000
    } top_state_t;

    top_state_t                state_reg, state_next;
    logic [SAMPLE_W-1:0]       lower_reg, upper_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic [IDX_W-1:0]          wr_idx_reg;
    logic signed [OFS_W-1:0]   ofs_reg, ofs_next;
    logic [SAMPLE_W-1:0]       last_mode_reg, last_mode_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic signed [DIAL_W-1:0]  held_reg, held_next;
    logic                      out_valid_reg;
    logic                      out_done_reg;
    logic signed [DIAL_W-1:0]  out_dial_reg;
    logic [SAMPLE_W-1:0]       out_mode_reg;

    logic                      cfg_wr;
    logic                      in_acc;
    logic                      out_free;
    logic                      win_last;
    logic                      start;
    logic                      load_out;
    logic                      load_done;
    logic [IDX_W-1:0]          rd_addr;
    logic [SAMPLE_W-1:0]       rd_data;
    dmfwj_mode_res_t           mres;

    logic signed [POS_W-1:0]   m_s, lo_s, hi_s, ofs_s;
    logic signed [OFS_W-1:0]   ofs_dn, ofs_up;
    logic signed [POS_W+GAIN_W:0] prod;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RST;
            upper_reg <= UPPER_RST;
            gain_reg  <= GAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LOWER: lower_reg <= pwdata[SAMPLE_W-1:0];
                REG_UPPER: upper_reg <= pwdata[SAMPLE_W-1:0];
                REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LOWER: prdata = APB_DW'(lower_reg);
            REG_UPPER: prdata = APB_DW'(upper_reg);
            REG_GAIN:  prdata = APB_DW'(gain_reg);
            default:   prdata = '0;
        endcase
    end

    // stream handshakes
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == T_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign win_last = (wr_idx_reg == LAST_IDX);
    assign start    = in_acc && win_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
        end
        else if (in_acc)
        begin
            wr_idx_reg <= win_last ? '0 : IDX_W'(wr_idx_reg + 1'b1);
        end
    end

    dmfwj_window_mem #(
        .DEPTH  (WINDOW_SIZE),
        .ADDR_W (IDX_W),
        .DATA_W (SAMPLE_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (wr_idx_reg),
        .wr_data (s_tdata[SAMPLE_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dmfwj_mode_unit #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .IDX_W       (IDX_W)
    ) u_mode (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (mres)
    );

    // offset step and position
    assign m_s    = $signed(POS_W'(mres.mode));
    assign lo_s   = $signed(POS_W'(lower_reg));
    assign hi_s   = $signed(POS_W'(upper_reg));
    assign ofs_s  = POS_W'(ofs_reg);
    assign ofs_dn = (ofs_reg != OFS_MIN) ? OFS_W'(ofs_reg - OFS_W'(1)) : ofs_reg;
    assign ofs_up = (ofs_reg != OFS_MAX) ? OFS_W'(ofs_reg + OFS_W'(1)) : ofs_reg;
    assign prod   = pos_reg * $signed({1'b0, gain_reg});

    always_comb
    begin
        state_next     = state_reg;
        ofs_next       = ofs_reg;
        last_mode_next = last_mode_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        load_out       = 1'b0;
        load_done      = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    state_next = T_SCAN;
                end
                else if (in_acc)
                begin
                    load_out = 1'b1;
                end
            end
            T_SCAN:
            begin
                if (mres.done)
                begin
                    last_mode_next = mres.mode;
                    priority if (mres.mode < lower_reg)
                    begin
                        ofs_next = ofs_dn;
                        pos_next = POS_W'(ofs_dn);
                    end
                    else if (mres.mode > upper_reg)
                    begin
                        ofs_next = ofs_up;
                        pos_next = POS_W'(ofs_up) + hi_s - lo_s;
                    end
                    else
                    begin
                        pos_next = m_s - lo_s + ofs_s;
                    end
                    state_next = T_MUL;
                end
            end
            T_MUL:
            begin
                held_next  = prod[DIAL_W-1:0];
                state_next = T_OUT;
            end
            T_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_done  = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            ofs_reg       <= '0;
            last_mode_reg <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ofs_reg       <= ofs_next;
            last_mode_reg <= last_mode_next;
            held_reg      <= held_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (load_out)
        begin
            out_done_reg <= load_done;
            out_dial_reg <= held_reg;
            out_mode_reg <= last_mode_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_mode_reg, out_dial_reg};
    assign m_tuser  = out_done_reg;

endmodule

// ===== rtl/dmfwj_window_mem.sv =====
// dmfwj_window_mem: sample window storage, one write and one registered read port.
// Depends on nothing.
module dmfwj_window_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dmfwj_mode_unit.sv =====
// dmfwj_mode_unit: finds the window mode with one shared equality compare,
// stepping a reference index and a scan index over the window memory.
// Depends on dmfwj_pkg.
module dmfwj_mode_unit
    import dmfwj_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int IDX_W       = $clog2(WINDOW_SIZE)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [SAMPLE_W-1:0] rd_data,
    output dmfwj_mode_res_t     res
);

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_REF  = 5'b00010,
        M_REFW = 5'b00100,
        M_SCAN = 5'b01000,
        M_BEST = 5'b10000
    } mode_state_t;

    mode_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    best_cnt_reg, best_cnt_next;
    logic [SAMPLE_W-1:0] ref_reg, ref_next;
    logic [SAMPLE_W-1:0] best_reg, best_next;
    logic                done_reg, done_next;
    logic                hit;

    assign hit = (rd_data == ref_reg);

    always_comb
    begin
        unique case (state_reg)
            M_REF:   rd_addr = i_reg;
            M_REFW:  rd_addr = '0;
            M_SCAN:  rd_addr = IDX_W'(j_reg + 1'b1);
            default: rd_addr = i_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        best_cnt_next = best_cnt_reg;
        ref_next      = ref_reg;
        best_next     = best_reg;
        done_next     = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    i_next        = '0;
                    best_cnt_next = '0;
                    state_next    = M_REF;
                end
            end
            M_REF:
            begin
                state_next = M_REFW;
            end
            M_REFW:
            begin
                ref_next   = rd_data;
                j_next     = '0;
                cnt_next   = '0;
                state_next = M_SCAN;
            end
            M_SCAN:
            begin
                if (hit)
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
                j_next = IDX_W'(j_reg + 1'b1);
                if (j_reg == LAST_IDX)
                begin
                    state_next = M_BEST;
                end
            end
            M_BEST:
            begin
                // later index wins a tie
                if (cnt_reg >= best_cnt_reg)
                begin
                    best_cnt_next = cnt_reg;
                    best_next     = ref_reg;
                end
                if (i_reg == LAST_IDX)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    i_next     = IDX_W'(i_reg + 1'b1);
                    state_next = M_REF;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        best_cnt_reg <= best_cnt_next;
        ref_reg      <= ref_next;
        best_reg     <= best_next;
    end

    assign res.done = done_reg;
    assign res.mode = best_reg;

endmodule

// ===== rtl/dmfwj_checker.sv =====
// dmfwj_checker: port-level assertions for the dial mode filter, bound to the top.
// Depends on dial_mode_filter_window_jog_top.
module dmfwj_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready || m_tvalid)
        else $error("input beat accepted without a result or busy window");

    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input ready while output beat stalled");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result beat appeared without an input beat");

endmodule

bind dial_mode_filter_window_jog_top dmfwj_checker u_dmfwj_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/dial_mode_filter_window_jog_top_tb.sv =====
// Self-checking testbench for dial_mode_filter_window_jog_top: drives sample beats,
// predicts every output beat with a cycle-free model and compares field by field.
// Depends on dmfwj_pkg and the dial mode filter RTL.
module dial_mode_filter_window_jog_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dmfwj_pkg::*;

    localparam int WIN             = WINDOW_SIZE_DEF;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_DIRECTED    = 25;
    localparam logic [APB_AW-1:0] ADDR_SPARE = 4'd12;  // past the last register

    typedef enum int {
        WIN_BELOW,
        WIN_INSIDE,
        WIN_ABOVE,
        WIN_FEW,
        WIN_SPREAD,
        WIN_NOISE
    } win_shape_t;

    typedef struct packed {
        logic [DIAL_W-1:0]   dial_value;
        logic                window_done;
        logic [SAMPLE_W-1:0] mode_reading;
    } dial_beat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                fixed_exp;
        dial_beat_t          beat;
    } stim_row_t;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{12'h000, 1'b1, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        // full window, mode above upper bound: offset 1, (1 + 2048) * 256
        '{12'hFFF, 1'b1, '{33'd524544, 1'b1, 12'hFFF}},
        '{12'h800, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'h7FF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hAAA, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'h555, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'h001, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hFFE, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'h3FF, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'h400, 1'b0, '{33'd0, 1'b0, 12'h000}},
        '{12'hC01, 1'b0, '{33'd0, 1'b0, 12'h000}}
    };

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // [11:0] sample
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;         // [32:0] dial_value, [44:33] mode_reading
    logic              m_tuser;         // [0] window_done

    logic              hold_off = 1'b0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                errors = 0;

    stim_row_t  stim_q [$];
    dial_beat_t expected_dial_q [$];

    // dial filter mirror
    logic [SAMPLE_W-1:0] win_q [WIN];
    int                  fill_idx;
    int                  jog_ofs;
    logic [SAMPLE_W-1:0] mode_q;
    logic [DIAL_W-1:0]   held_q;
    logic [SAMPLE_W-1:0] cfg_lower;
    logic [SAMPLE_W-1:0] cfg_upper;
    logic [GAIN_W-1:0]   cfg_gain;

    dial_mode_filter_window_jog_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("FAIL dial_mode_filter_window_jog_top");
        $finish;
    end

    function automatic dial_beat_t dial_filter_step(input logic [SAMPLE_W-1:0] smp);
        dial_beat_t          r;
        int                  best_cnt;
        int                  cnt;
        int                  lo;
        int                  hi;
        int                  m;
        int                  pos;
        longint              prod;
        logic [SAMPLE_W-1:0] best;
        r.window_done = 1'b0;
        win_q[fill_idx] = smp;
        fill_idx++;
        if (fill_idx == WIN)
        begin
            fill_idx = 0;
            r.window_done = 1'b1;
            best_cnt = 0;
            best = '0;
            for (int i = 0; i < WIN; i++)
            begin
                cnt = 0;
                for (int j = 0; j < WIN; j++)
                    if (win_q[j] == win_q[i])
                        cnt++;
                // later index wins a tie
                if (cnt >= best_cnt)
                begin
                    best_cnt = cnt;
                    best = win_q[i];
                end
            end
            mode_q = best;
            lo = int'(cfg_lower);
            hi = int'(cfg_upper);
            m = int'(mode_q);
            if (m < lo)
            begin
                if (jog_ofs > int'(OFS_MIN))
                    jog_ofs--;
                pos = jog_ofs;
            end
            else if (m > hi)
            begin
                if (jog_ofs < int'(OFS_MAX))
                    jog_ofs++;
                pos = jog_ofs + (hi - lo);
            end
            else
                pos = (m - lo) + jog_ofs;
            prod = longint'(pos) * longint'(cfg_gain);
            held_q = prod[DIAL_W-1:0];
        end
        r.dial_value = held_q;
        r.mode_reading = mode_q;
        return r;
    endfunction

    // sample sender
    always @(posedge clk)
    begin
        stim_row_t  row;
        dial_beat_t want;
        if (s_tvalid && s_tready)
        begin
            row = stim_q.pop_front();
            want = dial_filter_step(row.sample);
            if (row.fixed_exp)
                want = row.beat;
            expected_dial_q.push_back(want);
        end
        if (!s_tvalid || s_tready)
        begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, stim_q[0].sample};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dial_beat_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_dial_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: dial_value %0d mode %0d done %0b",
                         $time, $signed(m_tdata[32:0]), m_tdata[44:33], m_tuser);
            end
            else
            begin
                want = expected_dial_q.pop_front();
                if (m_tdata[32:0] !== want.dial_value)
                begin
                    errors++;
                    $display("%0t dial_value expected %0d got %0d", $time,
                             $signed(want.dial_value), $signed(m_tdata[32:0]));
                end
                if (m_tuser !== want.window_done)
                begin
                    errors++;
                    $display("%0t window_done expected %0b got %0b", $time,
                             want.window_done, m_tuser);
                end
                if (m_tdata[44:33] !== want.mode_reading)
                begin
                    errors++;
                    $display("%0t mode_reading expected %0d got %0d", $time,
                             want.mode_reading, m_tdata[44:33]);
                end
            end
        end
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    task automatic hold_receiver(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
                                input logic [GAIN_W-1:0] g);
        reg_write({REG_LOWER, 2'b00}, APB_DW'(lo));
        reg_write({REG_UPPER, 2'b00}, APB_DW'(hi));
        reg_write({REG_GAIN, 2'b00}, APB_DW'(g));
        cfg_lower = lo;
        cfg_upper = hi;
        cfg_gain = g;
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        stim_row_t row;
        while (stim_q.size() >= 4)
            @(posedge clk);
        row = '0;
        row.sample = smp;
        stim_q.push_back(row);
    endtask

    task automatic drain();
        while (stim_q.size() != 0 || s_tvalid || expected_dial_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value(input win_shape_t shape);
        logic [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom_range(4095));
        case (shape)
            WIN_BELOW:
                if (cfg_lower > 0)
                    v = SAMPLE_W'($urandom_range(int'(cfg_lower) - 1, 0));
            WIN_ABOVE:
                if (cfg_upper < 12'hFFF)
                    v = SAMPLE_W'($urandom_range(4095, int'(cfg_upper) + 1));
            WIN_INSIDE:
                if (cfg_lower <= cfg_upper)
                    v = SAMPLE_W'($urandom_range(int'(cfg_upper), int'(cfg_lower)));
            default:
                case ($urandom_range(6))
                    0: v = '0;
                    1: v = '1;
                    2: v = cfg_lower;
                    3: v = cfg_upper;
                    4: v = cfg_lower - 1'b1;
                    5: v = cfg_upper + 1'b1;
                    default: ;
                endcase
        endcase
        return v;
    endfunction

    task automatic queue_window(input win_shape_t shape, output int n);
        logic [SAMPLE_W-1:0] target;
        logic [SAMPLE_W-1:0] pool [3];
        n = WIN;
        case (shape)
            WIN_BELOW, WIN_INSIDE, WIN_ABOVE:
            begin
                target = pick_value(shape);
                for (int i = 0; i < WIN; i++)
                    push_sample($urandom_range(1) ? target : SAMPLE_W'($urandom_range(4095)));
            end
            WIN_FEW:
            begin
                foreach (pool[k])
                    pool[k] = pick_value(WIN_FEW);
                for (int i = 0; i < WIN; i++)
                    push_sample(pool[$urandom_range(2)]);
            end
            WIN_SPREAD:
                for (int i = 0; i < WIN; i++)
                    push_sample(SAMPLE_W'($urandom_range(4095)));
            default:
            begin
                // short burst of 1 to WIN-1 samples to move the window phase
                n = $urandom_range(WIN - 1, 1);
                for (int i = 0; i < n; i++)
                    push_sample(SAMPLE_W'($urandom_range(4095)));
            end
        endcase
    endtask

    initial
    begin
        int         pushed;
        int         n;
        win_shape_t shape;
        fill_idx = 0;
        jog_ofs = 0;
        mode_q = '0;
        held_q = '0;
        cfg_lower = LOWER_RST;
        cfg_upper = UPPER_RST;
        cfg_gain = GAIN_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            while (stim_q.size() >= 4)
                @(posedge clk);
            stim_q.push_back(DIRECTED[r]);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: program_regs(LOWER_RST, UPPER_RST, GAIN_RST);
                1: program_regs(12'd0, 12'hFFF, 16'hFFFF);
                2: program_regs(12'hFFF, 12'd0, 16'd1);
                3: program_regs(12'd2048, 12'd2048, 16'd0);
                4:
                begin
                    pushed = $urandom_range(4095);
                    n = $urandom_range(4095);
                    if (pushed > n)
                        program_regs(SAMPLE_W'(n), SAMPLE_W'(pushed),
                                     GAIN_W'($urandom_range(65535)));
                    else
                        program_regs(SAMPLE_W'(pushed), SAMPLE_W'(n),
                                     GAIN_W'($urandom_range(65535)));
                end
                default:
                begin
                    program_regs(12'd300, 12'd3900, 16'hFFFF);
                    reg_write(ADDR_SPARE, 32'h0000_0123);
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            if (p == 4)
                fork
                    hold_receiver(600);
                join_none
            pushed = 0;
            while (pushed < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(9))
                    0, 1: shape = WIN_BELOW;
                    2, 3: shape = WIN_INSIDE;
                    4, 5: shape = WIN_ABOVE;
                    6, 7: shape = WIN_FEW;
                    8: shape = WIN_SPREAD;
                    default: shape = WIN_NOISE;
                endcase
                queue_window(shape, n);
                pushed += n;
            end
            drain();
        end

        repeat (320) @(posedge clk);
        if (errors == 0)
            $display("PASS dial_mode_filter_window_jog_top");
        else
            $display("FAIL dial_mode_filter_window_jog_top");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dmfwj_pkg.sv
rtl/dmfwj_window_mem.sv
rtl/dmfwj_mode_unit.sv
rtl/dial_mode_filter_window_jog_top.sv
rtl/dmfwj_checker.sv
sim/dial_mode_filter_window_jog_top_tb.sv
